// File: src/lprl_pkg.sv
// ----------------------------------------------------------------------------
// lprl_pkg
// Types and field widths shared by the route lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package lprl_pkg;

  localparam int unsigned IDX_W  = 10;  // entry_index / match_index
  localparam int unsigned ADDR_W = 32;  // prefixes, masks, addresses
  localparam int unsigned PORT_W = 8;   // output interface number
  localparam int unsigned CNT_W  = 11;  // route_count register

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [PORT_W-1:0] port;
  } entry_t;

  // sequencer -> compare unit
  typedef struct packed {
    logic clear;  // start of a lookup
    logic valid;  // table read data is present this cycle
  } cmp_ctrl_t;

endpackage

`default_nettype wire

// File: src/lprl_if.sv
// ----------------------------------------------------------------------------
// lprl_req_if / lprl_rsp_if
// Valid/ready channels for lookup/write requests and lookup responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface lprl_req_if;
  import lprl_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [IDX_W-1:0]  entry_index;
  logic [ADDR_W-1:0] entry_prefix;
  logic [ADDR_W-1:0] entry_mask;
  logic [PORT_W-1:0] entry_port;
  logic [ADDR_W-1:0] dest_addr;

  modport source (output valid, mode, entry_index, entry_prefix, entry_mask,
                  entry_port, dest_addr, input ready);
  modport sink   (input valid, mode, entry_index, entry_prefix, entry_mask,
                  entry_port, dest_addr, output ready);
endinterface

interface lprl_rsp_if;
  import lprl_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [PORT_W-1:0] out_port;
  logic [IDX_W-1:0]  match_index;

  modport source (output valid, found, out_port, match_index, input ready);
  modport sink   (input valid, found, out_port, match_index, output ready);
endinterface

`default_nettype wire

// File: src/lprl_table.sv
// ----------------------------------------------------------------------------
// lprl_table
// Routing table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lprl_table
  import lprl_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/lprl_best.sv
// ----------------------------------------------------------------------------
// lprl_best
// Shared match/compare unit: checks one entry per cycle, while ctrl.valid
// is high, against the destination and keeps the best match seen so far.
// ----------------------------------------------------------------------------
`default_nettype none

module lprl_best
  import lprl_pkg::*;
#(
  parameter int unsigned AW = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmp_ctrl_t         ctrl,
  input  wire logic [ADDR_W-1:0] dest,
  input  wire entry_t            entry,
  input  wire logic [AW-1:0]     entry_idx,
  output logic                   hit,
  output logic [PORT_W-1:0]      best_port,
  output logic [AW-1:0]          best_idx
);

  logic [ADDR_W-1:0] best_mask;
  logic              match;
  logic              better;

  assign match  = (dest & entry.mask) == entry.prefix;
  // strict greater keeps the lowest index on equal masks
  assign better = match && (!hit || (entry.mask > best_mask));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      hit <= 1'b0;
    end else if (ctrl.valid && better) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid && better) begin
      best_mask <= entry.mask;
      best_port <= entry.port;
      best_idx  <= entry_idx;
    end
  end

endmodule

`default_nettype wire

// File: src/longest_prefix_route_lookup.sv
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup
// Longest-prefix-match routing table with a sequential one-entry-per-cycle
// search.
//
//   channel   dir  handshake          payload
//   req       in   valid/ready        mode, entry_*, dest_addr
//   rsp       out  valid/ready        found, out_port, match_index
//   cfg       in   cfg_wr_en          cfg_wr_data -> route_count
//
// A write request is stored at its accept edge.
// A lookup scans route_count entries (capped at TABLE_DEPTH): the
// single table read port delivers one entry per cycle to the compare unit.
// req.ready is low while a lookup runs; the result waits in the rsp register
// and the block keeps taking writes and the next lookup meanwhile.
// Synchronous reset clears control state; table contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_prefix_route_lookup
  import lprl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  lprl_req_if.sink              req,
  lprl_rsp_if.source            rsp,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  route_count;
  logic [CW-1:0]     limit;
  logic [CW-1:0]     limit_next;
  logic [CW-1:0]     cnt;
  logic [ADDR_W-1:0] dest;
  logic              cmp_valid;
  logic [AW-1:0]     cmp_idx;
  logic              issue;
  logic              req_fire;
  logic              lookup_fire;
  logic              wr_en;
  entry_t            wr_entry;
  entry_t            rd_entry;
  cmp_ctrl_t         ctrl;
  logic              hit;
  logic [PORT_W-1:0] best_port;
  logic [AW-1:0]     best_idx;

  logic              rsp_valid;
  logic              rsp_found;
  logic [PORT_W-1:0] rsp_port;
  logic [IDX_W-1:0]  rsp_index;

  assign req.ready   = (state == IDLE);
  assign req_fire    = req.valid && req.ready;
  assign lookup_fire = req_fire && (req.mode == MODE_LOOKUP);
  assign wr_en       = req_fire && (req.mode == MODE_WRITE)
                       && (32'(req.entry_index) < 32'(TABLE_DEPTH));
  assign wr_entry    = '{prefix: req.entry_prefix, mask: req.entry_mask,
                         port: req.entry_port};

  assign limit_next = (32'(route_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                            : CW'(route_count);
  assign issue      = (state == SCAN) && (cnt != limit);
  assign ctrl       = '{clear: lookup_fire, valid: cmp_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
    end else if (cfg_wr_en) begin
      route_count <= cfg_wr_data;
    end
  end

  lprl_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(req.entry_index)),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (cnt[AW-1:0]),
    .rd_data (rd_entry)
  );

  lprl_best #(
    .AW (AW)
  ) u_best (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .dest      (dest),
    .entry     (rd_entry),
    .entry_idx (cmp_idx),
    .hit       (hit),
    .best_port (best_port),
    .best_idx  (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      cmp_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      cmp_valid <= issue;
      if (state == FINISH && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (lookup_fire) begin
            state <= SCAN;
            cnt   <= '0;
            limit <= limit_next;
            dest  <= req.dest_addr;
          end
        end
        SCAN: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
          end else if (!cmp_valid) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_found <= hit;
            rsp_port  <= hit ? best_port : '0;
            rsp_index <= hit ? IDX_W'(best_idx) : '0;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cnt[AW-1:0];
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.found       = rsp_found;
  assign rsp.out_port    = rsp_port;
  assign rsp.match_index = rsp_index;

endmodule

`default_nettype wire

// File: src/lprl_checker.sv
// ----------------------------------------------------------------------------
// lprl_checker
// Port-level checks for the route lookup block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lprl_checker
  import lprl_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire logic              req_mode,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic              rsp_found,
  input wire logic [PORT_W-1:0] rsp_port,
  input wire logic [IDX_W-1:0]  rsp_index
);

  // a held response keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
      && $stable(rsp_port) && $stable(rsp_index))
    else $error("rsp changed while stalled");

  // a miss reports zero port and index
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_port == '0 && rsp_index == '0)
    else $error("miss with nonzero payload");

  // a lookup request blocks the request channel for the scan
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_mode == MODE_LOOKUP |=> !req_ready)
    else $error("ready after lookup accept");

  // writes never block the request channel
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_mode == MODE_WRITE |=> req_ready)
    else $error("not ready after write");

  // reset empties the response register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp valid after reset");

endmodule

bind longest_prefix_route_lookup lprl_checker u_lprl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_mode  (req.mode),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_found (rsp.found),
  .rsp_port  (rsp.out_port),
  .rsp_index (rsp.match_index)
);

`default_nettype wire
